/* sv/ewac_pkg.sv */
// Shared types and character constants of the email and web address classifier.
package ewac_pkg;

  // ASCII codes that the recognizers test against.
  localparam logic [7:0] ChAt    = 8'h40;
  localparam logic [7:0] ChUnder = 8'h5F;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChW     = 8'h77;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowZ  = 8'h7A;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch9     = 8'h39;

  // Verdict codes for a finished string.
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_EMAIL = 2'd1,
    KIND_WEB   = 2'd2
  } kind_e;

  // Character classes of one byte, as the front end decodes them.
  typedef struct packed {
    logic lower;
    logic upper;
    logic digit;
    logic at;
    logic dot;
    logic under;
    logic w;
  } cls_t;

  // One queue entry: the decoded byte and its end-of-string flag.
  typedef struct packed {
    cls_t cls;
    logic last;
  } entry_t;

  // Handshake between the queue and the back end.
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

endpackage

/* sv/ewac_if.sv */
// Channel interfaces for the byte input and the verdict output.
interface ewac_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

interface ewac_kind_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;

  modport source (output valid, output kind, input ready);
  modport sink   (input valid, input kind, output ready);
endinterface

/* sv/ewac_front.sv */
// Front end: accepts bytes and decodes their character classes for the queue.
module ewac_front
  import ewac_pkg::*;
(
  ewac_byte_if.sink byte_i,
  input  logic      full_i,
  output logic      push_o,
  output entry_t    entry_o
);

  logic [7:0] ch;

  // A byte is taken whenever the queue has room.
  assign byte_i.ready = !full_i;
  assign push_o       = byte_i.valid && !full_i;
  assign ch           = byte_i.byte_in;

  // Character class decode; bytes above 127 fall in no class.
  always_comb begin
    entry_o.cls.lower = (ch >= ChLowA) && (ch <= ChLowZ);
    entry_o.cls.upper = (ch >= ChUpA) && (ch <= ChUpZ);
    entry_o.cls.digit = (ch >= Ch0) && (ch <= Ch9);
    entry_o.cls.at    = (ch == ChAt);
    entry_o.cls.dot   = (ch == ChDot);
    entry_o.cls.under = (ch == ChUnder);
    entry_o.cls.w     = (ch == ChW);
    entry_o.last      = byte_i.last_byte;
  end

endmodule

/* sv/ewac_fifo.sv */
// Short queue of decoded bytes between the front end and the back end.
module ewac_fifo
  import ewac_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output head_t  head_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  entry_t          mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o       = (cnt_q == FullCnt);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.entry = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  // Pointer wrap and fill count.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage needs no reset; the fill count guards it.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

/* sv/ewac_back.sv */
// Back end: steps both recognizers and holds the verdict for the output channel.
module ewac_back
  import ewac_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  head_t       head_i,
  output logic        pop_o,
  ewac_kind_if.source kind_o
);

  typedef enum logic [2:0] {
    EM_START  = 3'd0,
    EM_LOCAL  = 3'd1,
    EM_DOMAIN = 3'd2,
    EM_DOT    = 3'd3,
    EM_VALID  = 3'd4,
    EM_REJECT = 3'd5
  } em_e;

  typedef enum logic [2:0] {
    WB_W1     = 3'd0,
    WB_W2     = 3'd1,
    WB_W3     = 3'd2,
    WB_PDOT   = 3'd3,
    WB_FIRST  = 3'd4,
    WB_NAME   = 3'd5,
    WB_VALID  = 3'd6,
    WB_REJECT = 3'd7
  } wb_e;

  em_e   em_q, em_d;
  wb_e   wb_q, wb_d;
  logic  out_valid_q;
  kind_e kind_q;
  cls_t  c;
  logic  alpha, alnum;

  assign c     = head_i.entry.cls;
  assign alpha = c.lower || c.upper;
  assign alnum = alpha || c.digit;

  // A final byte waits until the output register is free or being emptied.
  assign pop_o = head_i.valid && (!head_i.entry.last || !out_valid_q || kind_o.ready);

  // Email recognizer transition.
  always_comb begin
    unique case (em_q)
      EM_START:  em_d = alnum ? EM_LOCAL : EM_REJECT;
      EM_LOCAL:  em_d = c.at ? EM_DOMAIN :
                        (alnum || c.dot || c.under) ? EM_LOCAL : EM_REJECT;
      EM_DOMAIN: em_d = alpha ? EM_DOMAIN : (c.dot ? EM_DOT : EM_REJECT);
      EM_DOT:    em_d = c.lower ? EM_VALID : EM_REJECT;
      EM_VALID:  em_d = (c.lower || c.dot) ? EM_VALID : EM_REJECT;
      default:   em_d = EM_REJECT;
    endcase
  end

  // Web recognizer transition.
  always_comb begin
    unique case (wb_q)
      WB_W1:     wb_d = c.w ? WB_W2 : WB_REJECT;
      WB_W2:     wb_d = c.w ? WB_W3 : WB_REJECT;
      WB_W3:     wb_d = c.w ? WB_PDOT : WB_REJECT;
      WB_PDOT:   wb_d = c.dot ? WB_FIRST : WB_REJECT;
      WB_FIRST:  wb_d = c.lower ? WB_NAME : WB_REJECT;
      WB_NAME:   wb_d = c.lower ? WB_NAME : (c.dot ? WB_VALID : WB_REJECT);
      WB_VALID:  wb_d = c.lower ? WB_VALID : WB_REJECT;
      WB_REJECT: wb_d = WB_REJECT;
      default:   wb_d = WB_REJECT;
    endcase
  end

  assign kind_o.valid = out_valid_q;
  assign kind_o.kind  = kind_q;

  // Recognizer state and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_q        <= EM_START;
      wb_q        <= WB_W1;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_NONE;
    end else begin
      // The verdict stays until taken and is refilled at each string end.
      out_valid_q <= (out_valid_q && !kind_o.ready) || (pop_o && head_i.entry.last);
      if (pop_o) begin
        if (head_i.entry.last) begin
          // End of string: report, email first, and restart both recognizers.
          if (em_d == EM_VALID) begin
            kind_q <= KIND_EMAIL;
          end else if (wb_d == WB_VALID) begin
            kind_q <= KIND_WEB;
          end else begin
            kind_q <= KIND_NONE;
          end
          em_q <= EM_START;
          wb_q <= WB_W1;
        end else begin
          em_q <= em_d;
          wb_q <= wb_d;
        end
      end
    end
  end

endmodule

/* sv/email_web_address_classifier.sv */
// Top level of the email and web address classifier.
// The block takes one byte of a string per cycle on byte_i while byte_i.ready is
// high, with last_byte set on the final byte, and delivers one verdict on kind_o
// per string: 1 for an email address, 2 for a web address, 0 for neither, email
// winning when both match. A byte is decoded into character classes as it is
// accepted and placed in a queue of QUEUE_DEPTH entries; the back end takes one
// entry per cycle unless a final byte waits on a stalled kind_o, so the sustained
// rate is one byte per clock. The verdict is registered once the final byte
// has left the queue and is held in an output register until taken. byte_i.ready
// drops only while the queue is full, which happens when kind_o is stalled with a
// verdict pending and the next string's final byte reaches the head of the queue.
module email_web_address_classifier
  import ewac_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ewac_byte_if.sink   byte_i,
  ewac_kind_if.source kind_o
);

  logic   push, full, pop;
  entry_t entry;
  head_t  head;

  ewac_front u_front (
    .byte_i  (byte_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry)
  );

  ewac_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head)
  );

  ewac_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .kind_o (kind_o)
  );

endmodule

/* sv/ewac_checker.sv */
// Port-level checker for the classifier, bound to the top level.
module ewac_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_last_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] out_kind_i
);

  logic [7:0] pending_q;
  logic       in_fin, out_fin;

  assign in_fin  = in_valid_i && in_ready_i && in_last_i;
  assign out_fin = out_valid_i && out_ready_i;

  // Strings whose final byte was accepted but whose verdict is not yet taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_fin && !out_fin) begin
      pending_q <= pending_q + 1'b1;
    end else if (out_fin && !in_fin) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  // A verdict is only offered for a string that has ended.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pending_q != '0))
    else $error("verdict offered with no finished string pending");

  // The unused verdict code never shows.
  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_kind_i != 2'd3))
    else $error("verdict code 3 offered");

  // A stalled verdict holds its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_kind_i)))
    else $error("stalled verdict dropped or changed");

  // With no verdict waiting, a new byte is never refused.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q == '0) |-> in_ready_i)
    else $error("input stalled while nothing was pending");

endmodule

bind email_web_address_classifier ewac_checker u_ewac_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (byte_i.valid),
  .in_ready_i  (byte_i.ready),
  .in_last_i   (byte_i.last_byte),
  .out_valid_i (kind_o.valid),
  .out_ready_i (kind_o.ready),
  .out_kind_i  (kind_o.kind)
);
